FILE: design/note_list_json_parser_assert.svh
// Assertion macros for the note list parser.
// Used by the top level; no other dependencies.
`ifndef NOTE_LIST_JSON_PARSER_ASSERT_SVH
`define NOTE_LIST_JSON_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define NLJP_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define NLJP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define NLJP_ASSERT(lbl, ck, rst_n, prop, msg)
`define NLJP_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

FILE: design/nljp_pkg.sv
// Shared types, constants and key tables of the note list parser.
// No dependencies.
package nljp_pkg;

	localparam int unsigned KEY_BUFFER_BYTES_DEF = 32;
	localparam logic [31:0] NOTE_COUNT_MAX_DEF   = 32'd65535;
	localparam int unsigned MID_DEPTH            = 4;
	localparam int unsigned OUT_DEPTH            = 4;

	localparam logic [1:0] KIND_NOTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [1:0] KEY_FREQ  = 2'd0;
	localparam logic [1:0] KEY_DUR   = 2'd1;
	localparam logic [1:0] KEY_PAUSE = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] note_frequency;
		logic [31:0] note_duration;
		logic [31:0] note_pause;
		logic [15:0] notes_so_far;
		logic        last_result;
	} res_item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] text_byte;
		logic       eot;
		logic       nul;
		logic       ws;
		logic       digit;
		logic [3:0] dval;
		logic       lbrack;
		logic       rbrack;
		logic       lbrace;
		logic       rbrace;
		logic       colon;
		logic       comma;
		logic       quote;
	} cls_item_t;

	function automatic logic [3:0] key_len(input logic [1:0] k);
		logic [3:0] r;
		case (k)
			KEY_FREQ:  r = 4'd9;
			KEY_DUR:   r = 4'd8;
			KEY_PAUSE: r = 4'd5;
			default:   r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			KEY_FREQ: begin
				case (idx)
					4'd0: r = "f";
					4'd1: r = "r";
					4'd2: r = "e";
					4'd3: r = "q";
					4'd4: r = "u";
					4'd5: r = "e";
					4'd6: r = "n";
					4'd7: r = "c";
					4'd8: r = "y";
					default: r = 8'h00;
				endcase
			end
			KEY_DUR: begin
				case (idx)
					4'd0: r = "d";
					4'd1: r = "u";
					4'd2: r = "r";
					4'd3: r = "a";
					4'd4: r = "t";
					4'd5: r = "i";
					4'd6: r = "o";
					4'd7: r = "n";
					default: r = 8'h00;
				endcase
			end
			KEY_PAUSE: begin
				case (idx)
					4'd0: r = "p";
					4'd1: r = "a";
					4'd2: r = "u";
					4'd3: r = "s";
					4'd4: r = "e";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: design/nljp_fifo.sv
// Small synchronous queue with full/empty flags.
// Depends on nljp_pkg for the default depth.
module nljp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = nljp_pkg::MID_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wp_q;
	logic [AW:0]      rp_q;
	logic             do_wr;
	logic             do_rd;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end
endmodule

FILE: design/nljp_front.sv
// Byte classifier: tags whitespace, digits and structural characters.
// Depends on nljp_pkg.
module nljp_front (
	input  nljp_pkg::in_item_t  item,
	output nljp_pkg::cls_item_t cls
);
	import nljp_pkg::*;

	logic [7:0] b;
	logic [7:0] d;

	assign b = item.text_byte;
	assign d = b - CH_ZERO;

	always_comb begin
		cls           = '0;
		cls.text_byte = b;
		cls.eot       = item.end_of_text;
		cls.nul       = (b == 8'h00);
		cls.ws        = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
		cls.digit     = (d < 8'd10);
		cls.dval      = d[3:0];
		cls.lbrack    = (b == CH_LBRACK);
		cls.rbrack    = (b == CH_RBRACK);
		cls.lbrace    = (b == CH_LBRACE);
		cls.rbrace    = (b == CH_RBRACE);
		cls.colon     = (b == CH_COLON);
		cls.comma     = (b == CH_COMMA);
		cls.quote     = (b == CH_QUOTE);
	end
endmodule

FILE: design/nljp_back.sv
// Parser state machine: consumes classified bytes, writes notes and status.
// Depends on nljp_pkg.
module nljp_back #(
	parameter int unsigned KEY_BUFFER_BYTES = nljp_pkg::KEY_BUFFER_BYTES_DEF,
	parameter logic [31:0] NOTE_COUNT_MAX   = nljp_pkg::NOTE_COUNT_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nljp_pkg::cls_item_t cls,
	input  logic                cls_empty,
	output logic                cls_pop,
	input  logic                res_full,
	output logic                res_push,
	output nljp_pkg::res_item_t res
);
	import nljp_pkg::*;

	localparam int unsigned KW = $clog2(KEY_BUFFER_BYTES);
	localparam logic [KW-1:0] KEY_LAST = KW'(KEY_BUFFER_BYTES - 1);
	localparam logic [15:0] CNT_CAP =
		(NOTE_COUNT_MAX < 32'd65535) ? NOTE_COUNT_MAX[15:0] : 16'hFFFF;

	typedef enum logic [3:0] {
		PH_EXPECT_BRACKET, PH_ITEM_START, PH_ITEM_WS, PH_OBJ_TOP, PH_KEY_WS,
		PH_KEY_BODY, PH_COLON, PH_NUM_FIRST, PH_NUM_BODY, PH_AFTER_VALUE,
		PH_AFTER_OBJ, PH_AFTER_CLOSE, PH_FAILED, PH_HALTED
	} phase_t;

	phase_t        ph_q, n_ph;
	logic [KW-1:0] klen_q, n_klen;
	logic [2:0]    km_q, n_km;
	logic [31:0]   acc_q, n_acc;
	logic [31:0]   hf_q, n_hf;
	logic [31:0]   hd_q, n_hd;
	logic [31:0]   hp_q, n_hp;
	logic [2:0]    fp_q, n_fp;
	logic [15:0]   cnt_q, n_cnt;
	logic          bs_q, n_bs;
	logic          ep_q, n_ep;
	logic          pend_q;
	res_item_t     pend_res_q;

	logic          do_av, do_open, do_bkey, do_close, do_halt;
	logic          emit, status_err;
	logic [2:0]    len_eq, ch_eq;
	res_item_t     note_res, stat_res;
	logic          take;

	function automatic logic resolve(input phase_t p, input logic ep);
		logic r;
		case (p)
			PH_EXPECT_BRACKET: r = 1'b1;
			PH_ITEM_START, PH_ITEM_WS, PH_AFTER_OBJ,
			PH_AFTER_CLOSE, PH_FAILED: r = 1'b0;
			PH_HALTED: r = ep;
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	// incremental key compare against the three known names
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			len_eq[k] = (klen_q == KW'(key_len(2'(k))));
			ch_eq[k]  = (klen_q < KW'(key_len(2'(k)))) &&
				(key_char(2'(k), klen_q[3:0]) == cls.text_byte);
		end
	end

	assign take     = !cls_empty && !res_full && !pend_q;
	assign cls_pop  = take;
	// a held status waits for room in the result queue
	assign res_push = (pend_q && !res_full) || (take && (emit || cls.eot));

	always_comb begin
		n_ph = ph_q; n_klen = klen_q; n_km = km_q; n_acc = acc_q;
		n_hf = hf_q; n_hd = hd_q; n_hp = hp_q; n_fp = fp_q;
		n_cnt = cnt_q; n_bs = bs_q; n_ep = ep_q;
		do_av = 1'b0; do_open = 1'b0; do_bkey = 1'b0;
		do_close = 1'b0; do_halt = 1'b0; emit = 1'b0;

		if (ph_q != PH_HALTED) begin
			if (cls.nul) begin
				n_ep = resolve(ph_q, ep_q);
				n_ph = PH_HALTED;
			end else begin
				case (ph_q)
					PH_EXPECT_BRACKET: begin
						if (cls.lbrack) n_ph = PH_ITEM_START;
						else if (!cls.ws) do_halt = 1'b1;
					end
					PH_ITEM_START, PH_AFTER_OBJ: begin
						if (cls.rbrack) n_ph = PH_AFTER_CLOSE;
						else if (cls.lbrace) do_open = 1'b1;
						else if (ph_q == PH_AFTER_OBJ && (cls.ws || cls.comma))
							n_ph = cls.ws ? PH_AFTER_OBJ : PH_ITEM_START;
						else if (cls.ws) n_ph = PH_ITEM_WS;
						else n_ph = PH_FAILED;
					end
					PH_ITEM_WS: begin
						if (cls.lbrace) do_open = 1'b1;
						else if (!cls.ws) n_ph = PH_FAILED;
					end
					PH_AFTER_CLOSE: begin
						if (cls.lbrace) n_bs = 1'b1;
					end
					PH_FAILED: begin
						// a brace after a broken item turns it into an error
						if (cls.lbrace) begin
							n_bs    = 1'b1;
							do_halt = 1'b1;
						end
					end
					PH_OBJ_TOP: begin
						if (cls.rbrace) do_close = 1'b1;
						else if (cls.quote) do_bkey = 1'b1;
						else if (cls.ws) n_ph = PH_KEY_WS;
						else do_halt = 1'b1;
					end
					PH_KEY_WS: begin
						if (cls.quote) do_bkey = 1'b1;
						else if (!cls.ws) do_halt = 1'b1;
					end
					PH_KEY_BODY: begin
						if (cls.quote) begin
							n_km = km_q & len_eq;
							n_ph = PH_COLON;
						end else if (klen_q >= KEY_LAST) begin
							do_halt = 1'b1;
						end else begin
							n_km   = km_q & ch_eq;
							n_klen = klen_q + 1'b1;
						end
					end
					PH_COLON: begin
						if (cls.colon) n_ph = PH_NUM_FIRST;
						else if (!cls.ws) do_halt = 1'b1;
					end
					PH_NUM_FIRST: begin
						if (cls.digit) begin
							n_acc = {28'd0, cls.dval};
							n_ph  = PH_NUM_BODY;
						end else if (!cls.ws) begin
							do_halt = 1'b1;
						end
					end
					PH_NUM_BODY: begin
						if (cls.digit) begin
							n_acc = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
								+ {28'd0, cls.dval};
						end else begin
							if (km_q[KEY_FREQ])  begin n_hf = acc_q; n_fp[0] = 1'b1; end
							if (km_q[KEY_DUR])   begin n_hd = acc_q; n_fp[1] = 1'b1; end
							if (km_q[KEY_PAUSE]) begin n_hp = acc_q; n_fp[2] = 1'b1; end
							do_av = 1'b1;
						end
					end
					PH_AFTER_VALUE: do_av = 1'b1;
					default: ;
				endcase
			end
		end

		if (do_av) begin
			if (cls.ws) n_ph = PH_AFTER_VALUE;
			else if (cls.comma) n_ph = PH_OBJ_TOP;
			else if (cls.rbrace) do_close = 1'b1;
			else if (cls.quote) do_bkey = 1'b1;
			else do_halt = 1'b1;
		end
		if (do_open) begin
			n_bs = 1'b1;
			n_hf = '0; n_hd = '0; n_hp = '0; n_fp = '0;
			n_ph = PH_OBJ_TOP;
		end
		if (do_bkey) begin
			n_klen = '0;
			n_km   = 3'b111;
			n_ph   = PH_KEY_BODY;
		end
		if (do_close) begin
			if (n_fp[1:0] != 2'b11) begin
				do_halt = 1'b1;
			end else begin
				if (cnt_q < CNT_CAP) n_cnt = cnt_q + 1'b1;
				emit = 1'b1;
				n_ph = PH_AFTER_OBJ;
			end
		end
		if (do_halt) begin
			n_ph = PH_HALTED;
			n_ep = 1'b1;
		end

		note_res                = '0;
		note_res.result_kind    = KIND_NOTE;
		note_res.note_frequency = n_hf;
		note_res.note_duration  = n_hd;
		note_res.note_pause     = n_fp[2] ? n_hp : 32'd0;
		note_res.notes_so_far   = n_cnt;
		note_res.last_result    = !cls.eot;

		status_err              = resolve(n_ph, n_ep) || !n_bs;
		stat_res                = '0;
		stat_res.result_kind    = status_err ? KIND_ERROR : KIND_DONE;
		stat_res.notes_so_far   = n_cnt;
		stat_res.last_result    = 1'b1;

		if (pend_q) res = pend_res_q;
		else if (emit) res = note_res;
		else res = stat_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_EXPECT_BRACKET;
			klen_q <= '0;
			km_q   <= 3'b111;
			acc_q  <= '0;
			hf_q   <= '0;
			hd_q   <= '0;
			hp_q   <= '0;
			fp_q   <= '0;
			cnt_q  <= '0;
			bs_q   <= 1'b0;
			ep_q   <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !res_full) pend_q <= 1'b0;
			if (take) begin
				if (cls.eot) begin
					// text over: back to the reset state for the next text
					ph_q   <= PH_EXPECT_BRACKET;
					klen_q <= '0;
					km_q   <= 3'b111;
					acc_q  <= '0;
					hf_q   <= '0;
					hd_q   <= '0;
					hp_q   <= '0;
					fp_q   <= '0;
					cnt_q  <= '0;
					bs_q   <= 1'b0;
					ep_q   <= 1'b0;
					pend_q <= emit;
				end else begin
					ph_q   <= n_ph;
					klen_q <= n_klen;
					km_q   <= n_km;
					acc_q  <= n_acc;
					hf_q   <= n_hf;
					hd_q   <= n_hd;
					hp_q   <= n_hp;
					fp_q   <= n_fp;
					cnt_q  <= n_cnt;
					bs_q   <= n_bs;
					ep_q   <= n_ep;
				end
			end
		end
	end

	// status that follows a note from the same byte
	always_ff @(posedge clk) begin
		if (take && cls.eot && emit) begin
			pend_res_q <= stat_res;
		end
	end
endmodule

FILE: design/note_list_json_parser.sv
// Top level of the note list parser: classifier, byte queue, parser, result queue.
// Depends on nljp_pkg, nljp_front, nljp_fifo, nljp_back and the assertion header.
//
// Streaming parser for a bracketed list of note objects. Text bytes go in on a
// queue-style push/full port, one byte per cycle while the byte queue is not
// full; results come out on a queue-style empty/pop port. Each byte is
// classified on entry, waits in a four-entry byte queue, and is parsed by a
// state machine that handles one byte per cycle, unless the result queue is
// full or a status is held back, into a four-entry result queue. The result
// queue takes one write per cycle, so a final byte that both closes a note and
// ends the text has its status held back and written after the note. No
// configuration; state returns to reset after every end-of-text byte.
module note_list_json_parser #(
	parameter int unsigned KEY_BUFFER_BYTES = nljp_pkg::KEY_BUFFER_BYTES_DEF,
	parameter logic [31:0] NOTE_COUNT_MAX   = nljp_pkg::NOTE_COUNT_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nljp_pkg::in_item_t  text_item,
	output logic                full,
	input  logic                pop,
	output nljp_pkg::res_item_t result_item,
	output logic                empty
);
	import nljp_pkg::*;

	`include "note_list_json_parser_assert.svh"

	cls_item_t cls_in, cls_out;
	logic      cls_empty, cls_pop;
	logic      res_full, res_push;
	res_item_t res_wr;
	logic [$bits(cls_item_t)-1:0] cls_rdata;
	logic [$bits(res_item_t)-1:0] res_rdata;
	logic      res_is_status;
	logic      res_vals_zero;

	nljp_front u_front (
		.item (text_item),
		.cls  (cls_in)
	);

	nljp_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.rdata  (cls_rdata),
		.empty  (cls_empty)
	);

	assign cls_out = cls_item_t'(cls_rdata);

	nljp_back #(
		.KEY_BUFFER_BYTES (KEY_BUFFER_BYTES),
		.NOTE_COUNT_MAX   (NOTE_COUNT_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	nljp_fifo #(
		.WIDTH ($bits(res_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign result_item = res_item_t'(res_rdata);

	assign res_is_status = !empty && (result_item.result_kind != KIND_NOTE);
	assign res_vals_zero = (result_item.note_frequency == 32'd0) &&
		(result_item.note_duration == 32'd0) && (result_item.note_pause == 32'd0);

	`NLJP_ASSERT(a_no_write_when_full, clk, arst_n, res_push |-> !res_full, "result write while full")
	`NLJP_ASSERT(a_status_zero_values, clk, arst_n, res_is_status |-> res_vals_zero, "status values")
	`NLJP_ASSERT(a_status_is_last, clk, arst_n, res_is_status |-> result_item.last_result, "not last")
	`NLJP_ASSERT_ALWAYS(a_no_pop_when_empty, clk, cls_pop |-> !cls_empty, "byte read while empty")
endmodule
